// ===== src/fes_pkg.sv =====
// shared types, constants and helper functions of the frenet error unit
// no dependencies; every other file imports this package
`default_nettype none

package fes_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int T_BITS       = 30;
    localparam int TRIG_BITS    = 28;
    localparam int ANG_BITS     = 29;

    localparam int D_W     = 33;
    localparam int LEN_W   = 66;
    localparam int DOT_W   = 67;
    localparam int T_W     = T_BITS + 1;
    localparam int PSI_W   = 34;
    localparam int DXY_W   = 34;
    localparam int WRAP_W  = 36;
    localparam int PI_W    = FRAC_BITS + 3;
    localparam int TRIG_W  = 32;

    localparam longint PI_Q61      = 64'sd7244019458077122842;
    localparam longint PI_RAW      = (PI_Q61 + (longint'(1) <<< (60 - FRAC_BITS)))
                                     >>> (61 - FRAC_BITS);
    localparam longint PI_Q29      = (PI_Q61 + (longint'(1) <<< 31)) >>> 32;
    localparam longint HALF_PI_Q29 = (PI_Q61 + (longint'(1) <<< 32)) >>> 33;
    localparam longint TWO_PI_RAW  = 2 * PI_RAW;
    localparam longint WRAP_RECIP  = (longint'(1) <<< WRAP_W) / TWO_PI_RAW;
    localparam longint LEN_MIN     = (longint'(1) <<< (2 * FRAC_BITS))
                                     / 64'sd1000000000000;
    localparam longint GAIN_Q28    = 163008218;

    localparam int QDEPTH       = 8;
    localparam int QAW          = 3;
    localparam int QCW          = 4;
    localparam int FRONT_STAGES = 4;
    localparam int DIV_STAGES   = T_BITS;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_heading;
        logic signed [31:0] seg_start_x;
        logic signed [31:0] seg_start_y;
        logic signed [31:0] seg_end_x;
        logic signed [31:0] seg_end_y;
        logic signed [31:0] seg_start_heading;
        logic signed [31:0] seg_end_heading;
    } fes_in_t;

    typedef struct packed {
        logic signed [31:0] lateral_error;
        logic signed [31:0] heading_error;
    } fes_out_t;

    typedef enum logic [1:0] {
        T_ZERO,
        T_ONE,
        T_DIV
    } fes_tmode_t;

    // one classified item between front and back
    typedef struct packed {
        fes_tmode_t              mode;
        logic [LEN_W-1:0]        len2;
        logic [LEN_W-1:0]        rem;
        logic signed [D_W-1:0]   abx;
        logic signed [D_W-1:0]   aby;
        logic signed [D_W-1:0]   apx;
        logic signed [D_W-1:0]   apy;
        logic signed [31:0]      h0;
        logic signed [31:0]      th;
        logic signed [PI_W-1:0]  dh;
    } fes_job_t;

    typedef struct packed {
        logic           empty;
        logic           full;
        logic [QCW-1:0] count;
    } fes_qstat_t;

    // floor(n / d) for non-negative n and positive d by shift and subtract
    function automatic longint div_floor(input longint n, input longint d);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--)
        begin
            r = (r <<< 1) | ((n >>> b) & longint'(1));
            q = q <<< 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | longint'(1);
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q29 from a truncated series, evaluated at elaboration
    function automatic longint atan_q29(input int i);
        longint acc;
        longint term;
        int     e;
        acc = 0;
        if (i == 0)
            return ((PI_Q61 >>> 2) + (longint'(1) <<< 31)) >>> 32;
        for (int k = 0; k < 64; k++)
        begin
            e = 61 - i * (2 * k + 1);
            if (e < 0)
                break;
            term = div_floor(longint'(1) <<< e, longint'(2 * k + 1));
            acc  = ((k & 1) != 0) ? acc - term : acc + term;
        end
        return (acc + (longint'(1) <<< 31)) >>> 32;
    endfunction

    // shift right by s, rounding half away from zero
    function automatic logic signed [71:0] rnd_shift(input logic signed [71:0] v,
                                                     input int s);
        logic [71:0] m;
        m = v[71] ? (~v + 72'd1) : v;
        m = (m + (72'd1 << (s - 1))) >> s;
        return v[71] ? -$signed(m) : $signed(m);
    endfunction

endpackage

`default_nettype wire

// ===== src/fes_wrap.sv =====
// three-stage angle wrap into [-pi, pi] by reciprocal multiply and one correction
// depends on fes_pkg
`default_nettype none

module fes_wrap
    import fes_pkg::*;
(
    input  logic                     clk,
    input  logic signed [WRAP_W-1:0] a,
    output logic signed [PI_W-1:0]   y
);

    typedef enum logic [1:0] {
        WR_PASS,
        WR_HI,
        WR_LO
    } wr_mode_t;

    localparam int WX = WRAP_W + 1;
    localparam logic signed [WX-1:0] P_X   = WX'(PI_RAW);
    localparam logic [WRAP_W-1:0]    TP_U  = WRAP_W'(TWO_PI_RAW);
    localparam logic [WRAP_W-1:0]    RECIP = WRAP_W'(WRAP_RECIP);

    logic signed [WX-1:0]     ae;
    logic [WRAP_W-1:0]        u1_next;
    wr_mode_t                 m1_next;
    logic [2*WRAP_W-1:0]      prod;
    logic [2*WRAP_W-1:0]      qprod;
    logic [WRAP_W-1:0]        r0;
    logic [WRAP_W-1:0]        r;
    logic signed [WX-1:0]     rs;

    logic [WRAP_W-1:0]        u1_reg, u2_reg, u3_reg;
    wr_mode_t                 m1_reg, m2_reg, m3_reg;
    logic signed [PI_W-1:0]   p1_reg, p2_reg, p3_reg;
    logic [WRAP_W-1:0]        q2_reg, qt3_reg;

    // distance past the bound, minus one, so that the remainder lands the bound itself
    always_comb
    begin
        ae = WX'(a);
        if (ae > P_X)
        begin
            m1_next = WR_HI;
            u1_next = WRAP_W'(ae - P_X - WX'(1));
        end
        else if (ae < -P_X)
        begin
            m1_next = WR_LO;
            u1_next = WRAP_W'(-ae - P_X - WX'(1));
        end
        else
        begin
            m1_next = WR_PASS;
            u1_next = '0;
        end
    end

    assign prod  = u1_reg * RECIP;
    assign qprod = q2_reg * TP_U;

    always_ff @(posedge clk)
    begin
        u1_reg  <= u1_next;
        m1_reg  <= m1_next;
        p1_reg  <= PI_W'(a);
        u2_reg  <= u1_reg;
        m2_reg  <= m1_reg;
        p2_reg  <= p1_reg;
        q2_reg  <= prod[2*WRAP_W-1:WRAP_W];
        u3_reg  <= u2_reg;
        m3_reg  <= m2_reg;
        p3_reg  <= p2_reg;
        qt3_reg <= qprod[WRAP_W-1:0];
    end

    // quotient estimate is low by at most one
    always_comb
    begin
        r0 = u3_reg - qt3_reg;
        r  = (r0 >= TP_U) ? r0 - TP_U : r0;
        rs = $signed({1'b0, r});
        case (m3_reg)
            WR_HI:   y = PI_W'(rs - P_X + WX'(1));
            WR_LO:   y = PI_W'(P_X - WX'(1) - rs);
            default: y = p3_reg;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/fes_front.sv =====
// front end: differences, squared length and dot product, heading delta wrap,
// and classification of the projection fraction; depends on fes_pkg, fes_wrap
`default_nettype none

module fes_front
    import fes_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  fes_in_t  item,
    output logic     push,
    output fes_job_t job
);

    localparam logic [LEN_W-1:0] LEN_MIN_U = LEN_W'(LEN_MIN);

    logic signed [D_W-1:0]     abx_a_reg, aby_a_reg, apx_a_reg, apy_a_reg, dh_a_reg;
    logic signed [31:0]        h0_a_reg, th_a_reg;
    logic                      v_a_reg;

    logic signed [2*D_W-1:0]   sqx_b_reg, sqy_b_reg, pdx_b_reg, pdy_b_reg;
    logic signed [D_W-1:0]     abx_b_reg, aby_b_reg, apx_b_reg, apy_b_reg;
    logic signed [31:0]        h0_b_reg, th_b_reg;
    logic                      v_b_reg;

    logic [LEN_W-1:0]          len2_c_reg;
    logic signed [DOT_W-1:0]   dot_c_reg;
    logic signed [D_W-1:0]     abx_c_reg, aby_c_reg, apx_c_reg, apy_c_reg;
    logic signed [31:0]        h0_c_reg, th_c_reg;
    logic                      v_c_reg;

    fes_job_t                  job_d_reg;
    logic                      v_d_reg;

    logic [LEN_W:0]            len2_sum;
    logic                      dot_pos;
    logic                      long_seg;
    logic                      dot_ge;
    fes_tmode_t                mode_next;
    logic signed [PI_W-1:0]    dh_w;

    fes_wrap u_wrap (
        .clk (clk),
        .a   (WRAP_W'(dh_a_reg)),
        .y   (dh_w)
    );

    always_ff @(posedge clk)
    begin
        abx_a_reg <= D_W'(item.seg_end_x) - D_W'(item.seg_start_x);
        aby_a_reg <= D_W'(item.seg_end_y) - D_W'(item.seg_start_y);
        apx_a_reg <= D_W'(item.pos_x) - D_W'(item.seg_start_x);
        apy_a_reg <= D_W'(item.pos_y) - D_W'(item.seg_start_y);
        dh_a_reg  <= D_W'(item.seg_end_heading) - D_W'(item.seg_start_heading);
        h0_a_reg  <= item.seg_start_heading;
        th_a_reg  <= item.pos_heading;

        sqx_b_reg <= abx_a_reg * abx_a_reg;
        sqy_b_reg <= aby_a_reg * aby_a_reg;
        pdx_b_reg <= apx_a_reg * abx_a_reg;
        pdy_b_reg <= apy_a_reg * aby_a_reg;
        abx_b_reg <= abx_a_reg;
        aby_b_reg <= aby_a_reg;
        apx_b_reg <= apx_a_reg;
        apy_b_reg <= apy_a_reg;
        h0_b_reg  <= h0_a_reg;
        th_b_reg  <= th_a_reg;

        len2_c_reg <= len2_sum[LEN_W-1:0];
        dot_c_reg  <= DOT_W'(pdx_b_reg) + DOT_W'(pdy_b_reg);
        abx_c_reg  <= abx_b_reg;
        aby_c_reg  <= aby_b_reg;
        apx_c_reg  <= apx_b_reg;
        apy_c_reg  <= apy_b_reg;
        h0_c_reg   <= h0_b_reg;
        th_c_reg   <= th_b_reg;

        job_d_reg.mode <= mode_next;
        job_d_reg.len2 <= len2_c_reg;
        job_d_reg.rem  <= dot_c_reg[LEN_W-1:0];
        job_d_reg.abx  <= abx_c_reg;
        job_d_reg.aby  <= aby_c_reg;
        job_d_reg.apx  <= apx_c_reg;
        job_d_reg.apy  <= apy_c_reg;
        job_d_reg.h0   <= h0_c_reg;
        job_d_reg.th   <= th_c_reg;
        job_d_reg.dh   <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_d_reg <= 1'b0;
        end
        else
        begin
            v_a_reg <= accept;
            v_b_reg <= v_a_reg;
            v_c_reg <= v_b_reg;
            v_d_reg <= v_c_reg;
        end
    end

    assign len2_sum = (LEN_W + 1)'($unsigned(sqx_b_reg)) + (LEN_W + 1)'($unsigned(sqy_b_reg));

    always_comb
    begin
        dot_pos  = !dot_c_reg[DOT_W-1] && (dot_c_reg != '0);
        long_seg = len2_c_reg > LEN_MIN_U;
        dot_ge   = dot_c_reg >= $signed({1'b0, len2_c_reg});
        if (long_seg && dot_pos)
            mode_next = dot_ge ? T_ONE : T_DIV;
        else
            mode_next = T_ZERO;
    end

    // wrapped heading delta arrives in step with stage d
    always_comb
    begin
        job    = job_d_reg;
        job.dh = dh_w;
    end

    assign push = v_d_reg;

endmodule

`default_nettype wire

// ===== src/fes_queue.sv =====
// short item queue between front and back; the back drains it every cycle
// depends on fes_pkg
`default_nettype none

module fes_queue
    import fes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  fes_job_t   wdata,
    output logic       rvalid,
    output fes_job_t   rdata,
    output fes_qstat_t stat
);

    fes_job_t       mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0] count_reg, count_next;
    logic           pop;

    assign pop    = (count_reg != '0);
    assign rvalid = pop;
    assign rdata  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + QCW'(1);
            2'b01:   count_next = count_reg - QCW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            count_reg <= count_next;
        end
    end

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCW'(QDEPTH));
    assign stat.count = count_reg;

endmodule

`default_nettype wire

// ===== src/fes_div.sv =====
// pipelined restoring divider for the projection fraction, one quotient bit a stage
// depends on fes_pkg
`default_nettype none

module fes_div
    import fes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  fes_job_t          in_job,
    output logic              out_valid,
    output fes_job_t          out_job,
    output logic [T_BITS-1:0] out_q
);

    fes_job_t                job_reg [DIV_STAGES];
    logic [T_BITS-1:0]       q_reg   [DIV_STAGES];
    logic [DIV_STAGES-1:0]   v_reg;

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        fes_job_t          jin;
        fes_job_t          j_next;
        logic [T_BITS-1:0] qin;
        logic              vin;
        logic [LEN_W:0]    r2;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign jin = in_job;
            assign qin = '0;
            assign vin = in_valid;
        end
        else
        begin : g_rest
            assign jin = job_reg[k-1];
            assign qin = q_reg[k-1];
            assign vin = v_reg[k-1];
        end

        assign r2 = {jin.rem, 1'b0};
        assign ge = (r2 >= {1'b0, jin.len2});

        always_comb
        begin
            j_next     = jin;
            j_next.rem = ge ? LEN_W'(r2 - {1'b0, jin.len2}) : r2[LEN_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            job_reg[k] <= j_next;
            q_reg[k]   <= {qin[T_BITS-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else
                v_reg[k] <= vin;
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_job   = job_reg[DIV_STAGES-1];
    assign out_q     = q_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== src/fes_trig.sv =====
// back end after the divider: interpolation, angle wraps, cordic sin/cos,
// lateral error and output register; depends on fes_pkg, fes_wrap
`default_nettype none

module fes_trig
    import fes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  fes_job_t          job,
    input  logic [T_BITS-1:0] q,
    output logic              done,
    output fes_out_t          result
);

    localparam int PX_W  = T_W + 1 + D_W;
    localparam int PH_W  = T_W + 1 + PI_W;
    localparam int PR_W  = TRIG_W + DXY_W;
    localparam int SUM_W = PR_W + 1;
    localparam int WLAT  = 3;

    localparam logic signed [TRIG_W-1:0] HQ   = TRIG_W'(HALF_PI_Q29);
    localparam logic signed [TRIG_W-1:0] PQ   = TRIG_W'(PI_Q29);
    localparam logic signed [TRIG_W-1:0] GAIN = TRIG_W'(GAIN_Q28);
    localparam logic signed [71:0]       SMAX = 72'sd2147483647;
    localparam logic signed [71:0]       SMIN = -72'sd2147483648;

    typedef struct packed {
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [TRIG_W-1:0] z;
        logic                     flip;
        logic signed [DXY_W-1:0]  dx;
        logic signed [DXY_W-1:0]  dy;
        logic signed [PI_W-1:0]   herr;
    } cs_t;

    logic [T_W-1:0]            t;
    logic signed [T_W:0]       ts;

    logic signed [PX_W-1:0]    px1_reg, py1_reg;
    logic signed [PH_W-1:0]    ph1_reg;
    logic signed [D_W-1:0]     apx1_reg, apy1_reg;
    logic signed [31:0]        h01_reg, th1_reg;

    logic signed [DXY_W-1:0]   dx2_reg, dy2_reg;
    logic signed [PSI_W-1:0]   psi2_reg;
    logic signed [31:0]        th2_reg;

    logic signed [DXY_W-1:0]   dxd_reg [WLAT];
    logic signed [DXY_W-1:0]   dyd_reg [WLAT];

    logic signed [PI_W-1:0]    psi_w;
    logic signed [PI_W-1:0]    herr_w;
    logic signed [TRIG_W-1:0]  z29;
    cs_t                       c0_next;

    cs_t                       c_reg [CORDIC_STEPS+1];

    logic signed [TRIG_W-1:0]  s_v, c_v;
    logic signed [PR_W-1:0]    ps_reg, pc_reg;
    logic signed [PI_W-1:0]    herr_m_reg;
    logic signed [SUM_W-1:0]   sum;
    logic signed [71:0]        lat_r;
    logic signed [31:0]        lat_sat;

    fes_out_t                  result_reg;
    logic                      v1_reg, v2_reg, done_reg;
    logic [WLAT-1:0]           vw_reg;
    logic [CORDIC_STEPS:0]     vc_reg;
    logic                      vm_reg;

    always_comb
    begin
        case (job.mode)
            T_ONE:   t = T_W'(1) << T_BITS;
            T_DIV:   t = {1'b0, q};
            default: t = '0;
        endcase
        ts = $signed({1'b0, t});
    end

    always_ff @(posedge clk)
    begin
        px1_reg  <= ts * job.abx;
        py1_reg  <= ts * job.aby;
        ph1_reg  <= ts * job.dh;
        apx1_reg <= job.apx;
        apy1_reg <= job.apy;
        h01_reg  <= job.h0;
        th1_reg  <= job.th;

        dx2_reg  <= DXY_W'(apx1_reg) - DXY_W'(rnd_shift(72'(px1_reg), T_BITS));
        dy2_reg  <= DXY_W'(apy1_reg) - DXY_W'(rnd_shift(72'(py1_reg), T_BITS));
        psi2_reg <= PSI_W'(h01_reg) + PSI_W'(rnd_shift(72'(ph1_reg), T_BITS));
        th2_reg  <= th1_reg;

        dxd_reg[0] <= dx2_reg;
        dyd_reg[0] <= dy2_reg;
        for (int i = 1; i < WLAT; i++)
        begin
            dxd_reg[i] <= dxd_reg[i-1];
            dyd_reg[i] <= dyd_reg[i-1];
        end
    end

    fes_wrap u_wrap_psi (
        .clk (clk),
        .a   (WRAP_W'(psi2_reg)),
        .y   (psi_w)
    );

    fes_wrap u_wrap_head (
        .clk (clk),
        .a   (WRAP_W'(th2_reg) - WRAP_W'(psi2_reg)),
        .y   (herr_w)
    );

    // fold into the right half plane, negate both results at the end
    always_comb
    begin
        z29          = TRIG_W'(psi_w) <<< (ANG_BITS - FRAC_BITS);
        c0_next.x    = GAIN;
        c0_next.y    = '0;
        c0_next.dx   = dxd_reg[WLAT-1];
        c0_next.dy   = dyd_reg[WLAT-1];
        c0_next.herr = herr_w;
        if (z29 > HQ)
        begin
            c0_next.z    = z29 - PQ;
            c0_next.flip = 1'b1;
        end
        else if (z29 < -HQ)
        begin
            c0_next.z    = z29 + PQ;
            c0_next.flip = 1'b1;
        end
        else
        begin
            c0_next.z    = z29;
            c0_next.flip = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg[0] <= c0_next;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        localparam logic signed [TRIG_W-1:0] ANG = TRIG_W'(atan_q29(i));
        logic signed [TRIG_W-1:0] xs, ys;
        cs_t                      c_next;

        assign xs = c_reg[i].x >>> i;
        assign ys = c_reg[i].y >>> i;

        always_comb
        begin
            c_next = c_reg[i];
            if (!c_reg[i].z[TRIG_W-1])
            begin
                c_next.x = c_reg[i].x - ys;
                c_next.y = c_reg[i].y + xs;
                c_next.z = c_reg[i].z - ANG;
            end
            else
            begin
                c_next.x = c_reg[i].x + ys;
                c_next.y = c_reg[i].y - xs;
                c_next.z = c_reg[i].z + ANG;
            end
        end

        always_ff @(posedge clk)
        begin
            c_reg[i+1] <= c_next;
        end
    end

    assign s_v = c_reg[CORDIC_STEPS].flip ? -c_reg[CORDIC_STEPS].y : c_reg[CORDIC_STEPS].y;
    assign c_v = c_reg[CORDIC_STEPS].flip ? -c_reg[CORDIC_STEPS].x : c_reg[CORDIC_STEPS].x;

    always_ff @(posedge clk)
    begin
        ps_reg     <= s_v * c_reg[CORDIC_STEPS].dx;
        pc_reg     <= c_v * c_reg[CORDIC_STEPS].dy;
        herr_m_reg <= c_reg[CORDIC_STEPS].herr;
    end

    always_comb
    begin
        sum   = SUM_W'(pc_reg) - SUM_W'(ps_reg);
        lat_r = rnd_shift(72'(sum), TRIG_BITS);
        if (lat_r > SMAX)
            lat_sat = 32'sh7fffffff;
        else if (lat_r < SMIN)
            lat_sat = 32'sh80000000;
        else
            lat_sat = lat_r[31:0];
    end

    always_ff @(posedge clk)
    begin
        result_reg.lateral_error <= lat_sat;
        result_reg.heading_error <= 32'(herr_m_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vw_reg   <= '0;
            vc_reg   <= '0;
            vm_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            vw_reg   <= {vw_reg[WLAT-2:0], v2_reg};
            vc_reg   <= {vc_reg[CORDIC_STEPS-1:0], vw_reg[WLAT-1]};
            vm_reg   <= vc_reg[CORDIC_STEPS];
            done_reg <= vm_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== src/frenet_error_from_segment_unit.sv =====
// top level of the frenet lateral and heading error unit
// depends on fes_pkg, fes_front, fes_queue, fes_div, fes_trig
//
// Takes one pose and reference segment per clock while busy is low and
// returns the lateral error and wrapped heading error of each item, in order.
// The delay after acceptance is set by the 30-stage restoring divider for the
// projection fraction and the cordic pipeline. done marks a result for exactly
// one cycle and cannot be held off, so take result in that cycle. The back end
// drains the queue every cycle, so busy stays low in normal use.
`default_nettype none

module frenet_error_from_segment_unit
    import fes_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  fes_in_t  pose,
    output logic     done,
    output fes_out_t result
);

    localparam int BACK_LAT = DIV_STAGES + CORDIC_STEPS + 8;
    localparam logic signed [31:0] PI32 = 32'(PI_RAW);

    logic              accept;
    logic              f_push;
    fes_job_t          f_job;
    logic              q_valid;
    fes_job_t          q_job;
    fes_qstat_t        q_stat;
    logic              d_valid;
    fes_job_t          d_job;
    logic [T_BITS-1:0] d_q;

    // leave room for every item still in the front stages
    assign busy   = (q_stat.count > QCW'(QDEPTH - FRONT_STAGES - 1));
    assign accept = start && !busy;

    fes_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (pose),
        .push   (f_push),
        .job    (f_job)
    );

    fes_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (f_push),
        .wdata  (f_job),
        .rvalid (q_valid),
        .rdata  (q_job),
        .stat   (q_stat)
    );

    fes_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_job    (q_job),
        .out_valid (d_valid),
        .out_job   (d_job),
        .out_q     (d_q)
    );

    fes_trig u_trig (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (d_valid),
        .job      (d_job),
        .q        (d_q),
        .done     (done),
        .result   (result)
    );

    a_front_lat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##FRONT_STAGES f_push)
        else $error("front stage lost an item");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(f_push && q_stat.full))
        else $error("queue written while full");

    a_back_lat: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> ##BACK_LAT done)
        else $error("back end result missing");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.heading_error <= PI32) && (result.heading_error >= -PI32))
        else $error("heading error outside wrap range");

endmodule

`default_nettype wire
